/* hdl/scix_pkg.sv */
// Package for the segment / circle crossing block: word types, derived widths, stage counts.
// Used by every module of the block; depends on nothing.
package scix_pkg;

    // Coordinate width of every input and output field
    localparam int CB      = 8;
    // Fraction bits of the root and the quotient
    localparam int FRAC    = 16;

    // Derived widths
    localparam int DLW     = CB + 1;            // signed difference
    localparam int PRW     = 2 * DLW;           // signed product of two differences
    localparam int R2W     = 2 * CB;            // r*r
    localparam int DW      = 2 * CB + 1;        // squared length, squared distances
    localparam int PW      = 2 * CB + 3;        // signed dot / cross products
    localparam int QW      = 2 * CB + 1;        // magnitude of the cross product
    localparam int RLW     = R2W + DW;          // r*r*l2
    localparam int QQW     = 2 * QW;            // q*q
    localparam int RW      = 2 * CB + FRAC + 1; // root width
    localparam int XW      = 2 * RW;            // radicand width
    localparam int PADW    = XW - RLW - 2 * FRAC;
    localparam int UFW     = FRAC + 1;          // quotient width
    localparam int NW      = DW + FRAC;         // unsigned scaled parameter
    localparam int SNW     = PW + FRAC + 1;     // signed scaled parameter
    localparam int TW      = UFW + 1 + DLW;     // signed coordinate sum

    // Pipeline stage counts
    localparam int FRONT_ST = 5;
    localparam int SQ_ST    = RW;
    localparam int DIV_ST   = UFW + 1;
    localparam int CO_ST    = 2;
    localparam int SQ_OFS   = FRONT_ST;
    localparam int DIV_OFS  = SQ_OFS + SQ_ST;
    localparam int CO_OFS   = DIV_OFS + DIV_ST;
    localparam int NST      = CO_OFS + CO_ST;

    typedef struct packed {
        logic [CB-1:0] start_x;
        logic [CB-1:0] start_y;
        logic [CB-1:0] end_x;
        logic [CB-1:0] end_y;
        logic [CB-1:0] center_x;
        logic [CB-1:0] center_y;
        logic [CB-1:0] radius;
    } in_word_t;

    typedef struct packed {
        logic          intersects;
        logic          near_valid;
        logic [CB-1:0] near_x;
        logic [CB-1:0] near_y;
        logic          far_valid;
        logic [CB-1:0] far_x;
        logic [CB-1:0] far_y;
    } out_word_t;

    // Geometry carried alongside the root and the division
    typedef struct packed {
        logic [CB-1:0]           sx;
        logic [CB-1:0]           sy;
        logic signed [DLW-1:0]   dx;
        logic signed [DLW-1:0]   dy;
        logic signed [PW-1:0]    p;
        logic [DW-1:0]           l2;
        logic                    hit;
    } geo_t;

endpackage

/* hdl/scix_front.sv */
// Front end: differences, products, sums, hit test and radicand, five register stages.
// Depends on scix_pkg.
module scix_front (
    input  logic                              clk,
    input  scix_pkg::in_word_t                query,
    input  logic [scix_pkg::FRONT_ST-1:0]     ld,
    output scix_pkg::geo_t                    geo,
    output logic [scix_pkg::XW-1:0]           rad
);
    import scix_pkg::*;

    typedef logic signed [DLW-1:0] dl_t;
    typedef logic signed [PRW-1:0] pr_t;

    function automatic dl_t sdiff(input logic [CB-1:0] a, input logic [CB-1:0] b);
        return $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    // stage 1: differences
    logic [CB-1:0] sx1_reg, sy1_reg, r1_reg;
    dl_t           dx1_reg, dy1_reg, px1_reg, py1_reg, qx1_reg, qy1_reg;

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            sx1_reg <= query.start_x;
            sy1_reg <= query.start_y;
            r1_reg  <= query.radius;
            dx1_reg <= sdiff(query.end_x, query.start_x);
            dy1_reg <= sdiff(query.end_y, query.start_y);
            px1_reg <= sdiff(query.center_x, query.start_x);
            py1_reg <= sdiff(query.center_y, query.start_y);
            qx1_reg <= sdiff(query.center_x, query.end_x);
            qy1_reg <= sdiff(query.center_y, query.end_y);
        end
    end

    // stage 2: products
    logic [CB-1:0]  sx2_reg, sy2_reg;
    dl_t            dx2_reg, dy2_reg;
    logic [R2W-1:0] r22_reg;
    pr_t            pxx2_reg, pyy2_reg, qxx2_reg, qyy2_reg, dxx2_reg, dyy2_reg;
    pr_t            pdx2_reg, pdy2_reg, cra2_reg, crb2_reg;

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            sx2_reg  <= sx1_reg;
            sy2_reg  <= sy1_reg;
            dx2_reg  <= dx1_reg;
            dy2_reg  <= dy1_reg;
            r22_reg  <= r1_reg * r1_reg;
            pxx2_reg <= px1_reg * px1_reg;
            pyy2_reg <= py1_reg * py1_reg;
            qxx2_reg <= qx1_reg * qx1_reg;
            qyy2_reg <= qy1_reg * qy1_reg;
            dxx2_reg <= dx1_reg * dx1_reg;
            dyy2_reg <= dy1_reg * dy1_reg;
            pdx2_reg <= px1_reg * dx1_reg;
            pdy2_reg <= py1_reg * dy1_reg;
            cra2_reg <= px1_reg * dy1_reg;
            crb2_reg <= py1_reg * dx1_reg;
        end
    end

    // stage 3: sums and cross-product magnitude
    logic signed [PW-1:0] dp2_s, dq2_s, l2_s, p_s, cr_s, crm_s;
    assign dp2_s = PW'(pxx2_reg) + PW'(pyy2_reg);
    assign dq2_s = PW'(qxx2_reg) + PW'(qyy2_reg);
    assign l2_s  = PW'(dxx2_reg) + PW'(dyy2_reg);
    assign p_s   = PW'(pdx2_reg) + PW'(pdy2_reg);
    assign cr_s  = PW'(cra2_reg) - PW'(crb2_reg);
    assign crm_s = cr_s[PW-1] ? -cr_s : cr_s;

    logic [CB-1:0]        sx3_reg, sy3_reg;
    dl_t                  dx3_reg, dy3_reg;
    logic [R2W-1:0]       r23_reg;
    logic [DW-1:0]        dp23_reg, dq23_reg, l23_reg;
    logic signed [PW-1:0] p3_reg;
    logic [QW-1:0]        q3_reg;

    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            sx3_reg  <= sx2_reg;
            sy3_reg  <= sy2_reg;
            dx3_reg  <= dx2_reg;
            dy3_reg  <= dy2_reg;
            r23_reg  <= r22_reg;
            dp23_reg <= dp2_s[DW-1:0];
            dq23_reg <= dq2_s[DW-1:0];
            l23_reg  <= l2_s[DW-1:0];
            p3_reg   <= p_s;
            q3_reg   <= crm_s[QW-1:0];
        end
    end

    // stage 4: inside / zero-length tests, r*r*l2 and q*q
    logic [CB-1:0]        sx4_reg, sy4_reg;
    dl_t                  dx4_reg, dy4_reg;
    logic signed [PW-1:0] p4_reg;
    logic [DW-1:0]        l24_reg;
    logic                 inside4_reg, zero4_reg;
    logic [RLW-1:0]       rl4_reg;
    logic [QQW-1:0]       qq4_reg;

    always_ff @(posedge clk)
    begin
        if (ld[3])
        begin
            sx4_reg     <= sx3_reg;
            sy4_reg     <= sy3_reg;
            dx4_reg     <= dx3_reg;
            dy4_reg     <= dy3_reg;
            p4_reg      <= p3_reg;
            l24_reg     <= l23_reg;
            inside4_reg <= (dp23_reg < DW'(r23_reg)) && (dq23_reg < DW'(r23_reg));
            zero4_reg   <= (l23_reg == '0);
            rl4_reg     <= r23_reg * l23_reg;
            qq4_reg     <= q3_reg * q3_reg;
        end
    end

    // stage 5: miss test and radicand (r*r*l2 - q*q shifted up by 32 bits, zero unless hit)
    logic           miss, hit;
    logic [QQW-1:0] diff;
    assign miss = QQW'(rl4_reg) < qq4_reg;
    assign hit  = !inside4_reg && !zero4_reg && !miss;
    assign diff = QQW'(rl4_reg) - qq4_reg;

    geo_t           geo5_reg;
    logic [XW-1:0]  rad5_reg;

    always_ff @(posedge clk)
    begin
        if (ld[4])
        begin
            geo5_reg.sx  <= sx4_reg;
            geo5_reg.sy  <= sy4_reg;
            geo5_reg.dx  <= dx4_reg;
            geo5_reg.dy  <= dy4_reg;
            geo5_reg.p   <= p4_reg;
            geo5_reg.l2  <= l24_reg;
            geo5_reg.hit <= hit;
            rad5_reg     <= hit ? {{PADW{1'b0}}, diff[RLW-1:0], {(2*FRAC){1'b0}}} : '0;
        end
    end

    assign geo = geo5_reg;
    assign rad = rad5_reg;

endmodule

/* hdl/scix_sqrt.sv */
// Pipelined restoring square root, one root bit per register stage.
// Depends on scix_pkg.
module scix_sqrt (
    input  logic                           clk,
    input  scix_pkg::geo_t                 geo_in,
    input  logic [scix_pkg::XW-1:0]        rad,
    input  logic [scix_pkg::SQ_ST-1:0]     ld,
    output scix_pkg::geo_t                 geo_out,
    output logic [scix_pkg::RW-1:0]        root
);
    import scix_pkg::*;

    localparam int RMW = RW + 2;

    logic [RMW-1:0] rem_reg  [SQ_ST];
    logic [RW-1:0]  root_reg [SQ_ST];
    logic [XW-1:0]  x_reg    [SQ_ST];
    geo_t           geo_reg  [SQ_ST];

    for (genvar k = 0; k < SQ_ST; k++)
    begin : g_step
        logic [RMW-1:0] rem_in, cur, trial, rem_next;
        logic [RW-1:0]  root_in, root_next;
        logic [XW-1:0]  x_in;
        geo_t           g_in;
        logic           take;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = rad;
            assign g_in    = geo_in;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign x_in    = x_reg[k-1];
            assign g_in    = geo_reg[k-1];
        end

        // bring down the next two radicand bits and try root bit one
        assign cur       = {rem_in[RMW-3:0], x_in[XW-1 -: 2]};
        assign trial     = {root_in, 2'b01};
        assign take      = (cur >= trial);
        assign rem_next  = take ? (cur - trial) : cur;
        assign root_next = {root_in[RW-2:0], take};

        always_ff @(posedge clk)
        begin
            if (ld[k])
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                x_reg[k]    <= {x_in[XW-3:0], 2'b00};
                geo_reg[k]  <= g_in;
            end
        end
    end

    assign root    = root_reg[SQ_ST-1];
    assign geo_out = geo_reg[SQ_ST-1];

endmodule

/* hdl/scix_div.sv */
// Crossing parameters, range check, then two-lane pipelined restoring division by l2.
// Depends on scix_pkg.
module scix_div (
    input  logic                           clk,
    input  scix_pkg::geo_t                 geo_in,
    input  logic [scix_pkg::RW-1:0]        root,
    input  logic [scix_pkg::DIV_ST-1:0]    ld,
    output scix_pkg::geo_t                 geo_out,
    output logic [scix_pkg::UFW-1:0]       uf_near,
    output logic [scix_pkg::UFW-1:0]       uf_far,
    output logic                           near_ok,
    output logic                           far_ok
);
    import scix_pkg::*;

    // scaled parameters p*2^16 -/+ s and the bound l2*2^16
    logic signed [SNW-1:0] pf, sf, lim, nn, nf;
    logic                  okn, okf;
    assign pf  = $signed({{(SNW-PW-FRAC){geo_in.p[PW-1]}}, geo_in.p, {FRAC{1'b0}}});
    assign sf  = $signed({{(SNW-RW){1'b0}}, root});
    assign lim = $signed({{(SNW-NW){1'b0}}, geo_in.l2, {FRAC{1'b0}}});
    assign nn  = pf - sf;
    assign nf  = pf + sf;
    assign okn = geo_in.hit && !nn[SNW-1] && (nn <= lim);
    assign okf = geo_in.hit && !nf[SNW-1] && (nf <= lim);

    logic [NW-1:0] num0_reg [2];
    logic          ok0_reg  [2];
    geo_t          geo0_reg;

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            num0_reg[0] <= okn ? nn[NW-1:0] : '0;
            num0_reg[1] <= okf ? nf[NW-1:0] : '0;
            ok0_reg[0]  <= okn;
            ok0_reg[1]  <= okf;
            geo0_reg    <= geo_in;
        end
    end

    // division: one quotient bit per stage, dividend bits and quotient share lo
    logic [DW:0]     rem_reg [UFW][2];
    logic [UFW-1:0]  lo_reg  [UFW][2];
    logic            ok_reg  [UFW][2];
    geo_t            geo_reg [UFW];

    for (genvar j = 0; j < UFW; j++)
    begin : g_step
        geo_t g_in;

        if (j == 0)
        begin : g_first_geo
            assign g_in = geo0_reg;
        end
        else
        begin : g_rest_geo
            assign g_in = geo_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (ld[j+1])
            begin
                geo_reg[j] <= g_in;
            end
        end

        for (genvar ln = 0; ln < 2; ln++)
        begin : g_lane
            logic [DW:0]    rem_in, cur, dvs, rem_next;
            logic [UFW-1:0] lo_in, lo_next;
            logic           ok_in, ge;

            if (j == 0)
            begin : g_first
                assign rem_in = {2'b00, num0_reg[ln][NW-1:UFW]};
                assign lo_in  = num0_reg[ln][UFW-1:0];
                assign ok_in  = ok0_reg[ln];
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[j-1][ln];
                assign lo_in  = lo_reg[j-1][ln];
                assign ok_in  = ok_reg[j-1][ln];
            end

            assign cur      = {rem_in[DW-1:0], lo_in[UFW-1]};
            assign dvs      = {1'b0, g_in.l2};
            assign ge       = (cur >= dvs);
            assign rem_next = ge ? (cur - dvs) : cur;
            assign lo_next  = {lo_in[UFW-2:0], ge};

            always_ff @(posedge clk)
            begin
                if (ld[j+1])
                begin
                    rem_reg[j][ln] <= rem_next;
                    lo_reg[j][ln]  <= lo_next;
                    ok_reg[j][ln]  <= ok_in;
                end
            end
        end
    end

    assign geo_out = geo_reg[UFW-1];
    assign uf_near = lo_reg[UFW-1][0];
    assign uf_far  = lo_reg[UFW-1][1];
    assign near_ok = ok_reg[UFW-1][0];
    assign far_ok  = ok_reg[UFW-1][1];

endmodule

/* hdl/scix_coord.sv */
// Crossing coordinates: start*2^16 + uf*delta, clamped at zero and truncated, into the output register.
// Depends on scix_pkg.
module scix_coord (
    input  logic                           clk,
    input  scix_pkg::geo_t                 geo,
    input  logic [scix_pkg::UFW-1:0]       uf_near,
    input  logic [scix_pkg::UFW-1:0]       uf_far,
    input  logic                           near_ok,
    input  logic                           far_ok,
    input  logic [scix_pkg::CO_ST-1:0]     ld,
    output scix_pkg::out_word_t            result
);
    import scix_pkg::*;

    typedef logic signed [TW-1:0] t_t;

    function automatic logic [CB-1:0] trunc_coord(input logic [CB-1:0] s, input t_t prod);
        t_t t;
        t = $signed({{(TW-CB-FRAC){1'b0}}, s, {FRAC{1'b0}}}) + prod;
        return t[TW-1] ? '0 : t[CB+FRAC-1:FRAC];
    endfunction

    // stage 1: the four products
    t_t            mnx_reg, mny_reg, mfx_reg, mfy_reg;
    logic [CB-1:0] sx_reg, sy_reg;
    logic          hit_reg, nok_reg, fok_reg;

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            mnx_reg <= $signed({1'b0, uf_near}) * geo.dx;
            mny_reg <= $signed({1'b0, uf_near}) * geo.dy;
            mfx_reg <= $signed({1'b0, uf_far}) * geo.dx;
            mfy_reg <= $signed({1'b0, uf_far}) * geo.dy;
            sx_reg  <= geo.sx;
            sy_reg  <= geo.sy;
            hit_reg <= geo.hit;
            nok_reg <= near_ok;
            fok_reg <= far_ok;
        end
    end

    // stage 2: output word, invalid crossings read as zero
    out_word_t result_reg;

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            result_reg.intersects <= hit_reg;
            result_reg.near_valid <= nok_reg;
            result_reg.near_x     <= nok_reg ? trunc_coord(sx_reg, mnx_reg) : '0;
            result_reg.near_y     <= nok_reg ? trunc_coord(sy_reg, mny_reg) : '0;
            result_reg.far_valid  <= fok_reg;
            result_reg.far_x      <= fok_reg ? trunc_coord(sx_reg, mfx_reg) : '0;
            result_reg.far_y      <= fok_reg ? trunc_coord(sy_reg, mfy_reg) : '0;
        end
    end

    assign result = result_reg;

endmodule

/* hdl/segment_circle_intersection_top.sv */
// Segment / circle crossing, top level: valid chain, stall control and the pipeline.
// Depends on scix_pkg, scix_front, scix_sqrt, scix_div and scix_coord.
//
// Usage:
//   query channel  (query_valid / query_ready / query): one segment, centre and
//                  radius per word.
//   result channel (result_valid / result_ready / result): one result word per
//                  query, in query order.
//   Depth: 2*CB + 42 register stages: five front stages, one stage per root bit
//   (2*CB + 17) in the square root, one range stage plus seventeen quotient
//   stages in the divider, and two coordinate stages ending in the output register.
//   Throughput: one word per cycle while result_ready stays high.
//   Stall: when the output word is not taken, the full stages back up behind it
//   while empty stages keep filling, so query_ready stays high until every
//   stage holds a word. Nothing is dropped or repeated.
//   Reset: rst_n clears all stage valid bits; the pipeline comes up empty and
//   ready.
module segment_circle_intersection_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  query_valid,
    output logic                  query_ready,
    input  scix_pkg::in_word_t    query,
    output logic                  result_valid,
    input  logic                  result_ready,
    output scix_pkg::out_word_t   result
);
    import scix_pkg::*;

    // stage valid bits and per-stage load enables
    logic [NST-1:0] v_reg, v_next, hold, ld;
    logic           out_stall;

    assign out_stall = !result_ready;

    for (genvar k = 0; k < NST; k++)
    begin : g_hold
        assign hold[k] = out_stall && (&v_reg[NST-1:k]);
    end

    assign ld = ~hold;

    always_comb
    begin
        v_next = v_reg;
        if (ld[0])
        begin
            v_next[0] = query_valid;
        end
        for (int k = 1; k < NST; k++)
        begin
            if (ld[k])
            begin
                v_next[k] = v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign query_ready  = ld[0];
    assign result_valid = v_reg[NST-1];

    // datapath
    geo_t            geo_f, geo_s, geo_d;
    logic [XW-1:0]   rad;
    logic [RW-1:0]   root;
    logic [UFW-1:0]  uf_near, uf_far;
    logic            near_ok, far_ok;

    scix_front u_front (
        .clk   (clk),
        .query (query),
        .ld    (ld[FRONT_ST-1:0]),
        .geo   (geo_f),
        .rad   (rad)
    );

    scix_sqrt u_sqrt (
        .clk     (clk),
        .geo_in  (geo_f),
        .rad     (rad),
        .ld      (ld[DIV_OFS-1:SQ_OFS]),
        .geo_out (geo_s),
        .root    (root)
    );

    scix_div u_div (
        .clk     (clk),
        .geo_in  (geo_s),
        .root    (root),
        .ld      (ld[CO_OFS-1:DIV_OFS]),
        .geo_out (geo_d),
        .uf_near (uf_near),
        .uf_far  (uf_far),
        .near_ok (near_ok),
        .far_ok  (far_ok)
    );

    scix_coord u_coord (
        .clk     (clk),
        .geo     (geo_d),
        .uf_near (uf_near),
        .uf_far  (uf_far),
        .near_ok (near_ok),
        .far_ok  (far_ok),
        .ld      (ld[NST-1:CO_OFS]),
        .result  (result)
    );

endmodule

/* hdl/scix_checker.sv */
// Port-level checks for the segment / circle crossing block, bound to the top level.
// Depends on scix_pkg and segment_circle_intersection_top.
module scix_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  query_valid,
    input  logic                  query_ready,
    input  scix_pkg::in_word_t    query,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  scix_pkg::out_word_t   result
);
    import scix_pkg::*;

    // a stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // a free output never back-pressures the query side
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        result_ready |-> query_ready)
        else $error("query_ready low while result side is free");

    // a miss carries no crossings
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.intersects |->
            !result.near_valid && !result.far_valid &&
            result.near_x == '0 && result.near_y == '0 &&
            result.far_x == '0 && result.far_y == '0)
        else $error("crossing data on a miss");

    // an off-segment crossing reads as zero
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (!result.near_valid || !result.far_valid) |->
            (result.near_valid || (result.near_x == '0 && result.near_y == '0)) &&
            (result.far_valid || (result.far_x == '0 && result.far_y == '0)))
        else $error("coordinates on an invalid crossing");

endmodule

bind segment_circle_intersection_top scix_checker u_scix_checker (.*);

/* tb/sv/segment_circle_intersection_top_tb.sv */
// Testbench for segment_circle_intersection_top: directed and random queries with a
// bit-exact crossing predictor and an in-order scoreboard. Depends on scix_pkg and the DUT.
`timescale 1ns / 100ps

module segment_circle_intersection_top_tb;
    import scix_pkg::*;

    // Exact crossing predictor plus queue of expected result words
    class crossing_board;
        out_word_t pending[$];
        int        errors;

        function void note_query(in_word_t w);
            pending = {pending, predict(w)};
        endfunction

        static function logic [CB-1:0] coord_of(longint st, longint uf, longint d);
            longint t;
            begin
                t = st * 65536 + uf * d;
                if (t < 0)
                    t = 0;
                return t[CB+15:16];
            end
        endfunction

        // 128-bit integer square root, floor
        static function logic [63:0] isqrt(logic [127:0] x);
            logic [63:0]  r;
            logic [63:0]  c;
            logic [127:0] cc;
            begin
                r = '0;
                for (int b = 63; b >= 0; b--)
                begin
                    c  = r | (64'd1 << b);
                    cc = {64'd0, c} * {64'd0, c};
                    if (cc <= x)
                        r = c;
                end
                return r;
            end
        endfunction

        static function out_word_t predict(in_word_t w);
            out_word_t    o;
            longint       sx, sy, ex, ey, cx, cy, r, dx, dy, px, py, qx, qy;
            longint       r2, l2, p, q, s, n, lim, uf;
            logic [127:0] rl, qq, disc;
            begin
                o  = '0;
                sx = longint'(w.start_x); sy = longint'(w.start_y);
                ex = longint'(w.end_x); ey = longint'(w.end_y);
                cx = longint'(w.center_x); cy = longint'(w.center_y);
                r  = longint'(w.radius);
                dx = ex - sx; dy = ey - sy;
                px = cx - sx; py = cy - sy;
                qx = cx - ex; qy = cy - ey;
                r2 = r * r;
                l2 = dx * dx + dy * dy;
                if (px * px + py * py < r2 && qx * qx + qy * qy < r2)
                    return o;
                if (l2 == 0)
                    return o;
                p = px * dx + py * dy;
                q = px * dy - py * dx;
                if (q < 0)
                    q = -q;
                rl = 128'(r2) * 128'(l2);
                qq = 128'(q) * 128'(q);
                if (rl < qq)
                    return o;
                disc = (rl - qq) << 32;
                s    = longint'(isqrt(disc));
                o.intersects = 1'b1;
                lim = l2 * 65536;
                // near crossing
                n = p * 65536 - s;
                if (n >= 0 && n <= lim)
                begin
                    uf = n / l2;
                    o.near_valid = 1'b1;
                    o.near_x = coord_of(sx, uf, dx);
                    o.near_y = coord_of(sy, uf, dy);
                end
                // far crossing
                n = p * 65536 + s;
                if (n >= 0 && n <= lim)
                begin
                    uf = n / l2;
                    o.far_valid = 1'b1;
                    o.far_x = coord_of(sx, uf, dx);
                    o.far_y = coord_of(sy, uf, dy);
                end
                return o;
            end
        endfunction

        function void check_result(out_word_t got);
            out_word_t e;
            begin
                if (pending.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result word %h", $realtime, got);
                    return;
                end
                e = pending.pop_front();
                if (got.intersects !== e.intersects)
                    $display("%0t: intersects exp %0d got %0d", $realtime, e.intersects,
                             got.intersects);
                if (got.near_valid !== e.near_valid)
                    $display("%0t: near_valid exp %0d got %0d", $realtime, e.near_valid,
                             got.near_valid);
                if (got.near_x !== e.near_x)
                    $display("%0t: near_x exp %0d got %0d", $realtime, e.near_x, got.near_x);
                if (got.near_y !== e.near_y)
                    $display("%0t: near_y exp %0d got %0d", $realtime, e.near_y, got.near_y);
                if (got.far_valid !== e.far_valid)
                    $display("%0t: far_valid exp %0d got %0d", $realtime, e.far_valid,
                             got.far_valid);
                if (got.far_x !== e.far_x)
                    $display("%0t: far_x exp %0d got %0d", $realtime, e.far_x, got.far_x);
                if (got.far_y !== e.far_y)
                    $display("%0t: far_y exp %0d got %0d", $realtime, e.far_y, got.far_y);
                if (got !== e)
                    errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      query_valid;
    logic      query_ready;
    in_word_t  query;
    logic      result_valid;
    logic      result_ready;
    out_word_t result;

    crossing_board board;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        hold_off;
    longint    cycle_count;
    localparam longint CYCLE_LIMIT = 2000000;

    segment_circle_intersection_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query_valid),
        .query_ready  (query_ready),
        .query        (query),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        board          = new();
        rst_n          = 1'b0;
        query_valid    = 1'b0;
        query          = '0;
        result_ready   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off       = 0;
        cycle_count    = 0;
    end

    // Cycle limit watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: random stall, long hold-off when requested
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            board.check_result(result);
        if (hold_off > 0)
        begin
            hold_off     <= hold_off - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one query word and wait for it to be taken
    task automatic send_word(in_word_t w);
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                query_valid <= 1'b0;
                @(posedge clk);
            end
            query_valid <= 1'b1;
            query       <= w;
            @(posedge clk);
            while (!query_ready)
                @(posedge clk);
            board.note_query(w);
        end
    endtask

    function automatic in_word_t make_word(int a, int b, int c, int d, int e, int f, int g);
        in_word_t w;
        begin
            w.start_x = CB'(a); w.start_y = CB'(b); w.end_x = CB'(c); w.end_y = CB'(d);
            w.center_x = CB'(e); w.center_y = CB'(f); w.radius = CB'(g);
            return w;
        end
    endfunction

    // Random query: mostly local geometry that hits, some full-range noise
    function automatic in_word_t rand_word();
        in_word_t    w;
        int          k;
        logic [63:0] rnd;
        begin
            k   = $urandom_range(9);
            rnd = {$urandom, $urandom};
            w   = rnd[$bits(in_word_t)-1:0];
            if (k < 7)
            begin
                w.center_x = CB'($urandom_range(255));
                w.center_y = CB'($urandom_range(255));
                w.radius   = CB'($urandom_range(k < 2 ? 255 : 60));
                w.start_x  = CB'(w.center_x + $urandom_range(160) - 80);
                w.start_y  = CB'(w.center_y + $urandom_range(160) - 80);
                w.end_x    = CB'(w.center_x + $urandom_range(160) - 80);
                w.end_y    = CB'(w.center_y + $urandom_range(160) - 80);
            end
            return w;
        end
    endfunction

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, zero length, zero radius, tangent, inside, miss
        send_word(make_word(0, 0, 255, 255, 128, 128, 10));
        send_word(make_word(255, 255, 0, 0, 128, 128, 255));
        send_word(make_word(10, 10, 10, 10, 10, 10, 5));
        send_word(make_word(0, 0, 0, 0, 0, 0, 0));
        send_word(make_word(0, 5, 20, 5, 10, 5, 0));
        send_word(make_word(0, 0, 20, 0, 10, 5, 5));
        send_word(make_word(9, 10, 11, 10, 10, 10, 5));
        send_word(make_word(0, 0, 20, 0, 10, 50, 5));
        send_word(make_word(5, 10, 15, 10, 10, 10, 5));
        send_word(make_word(0, 10, 5, 10, 10, 10, 5));
        send_word(make_word(255, 0, 0, 255, 0, 0, 255));
        send_word(make_word(0, 255, 255, 0, 255, 255, 255));
        send_word(make_word(255, 255, 255, 255, 255, 255, 255));
        send_word(make_word(0, 0, 255, 0, 128, 0, 128));
        send_word(make_word(128, 0, 128, 255, 0, 128, 128));
        send_word(make_word(3, 4, 50, 70, 30, 33, 17));
        send_word(make_word(200, 30, 20, 210, 120, 120, 40));

        // Random phases with different idle mixes
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            if (ph == 0)
                hold_off = 300;
            for (int i = 0; i < 300; i++)
                send_word(rand_word());
        end
        query_valid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* sim.f */
hdl/scix_pkg.sv
hdl/scix_front.sv
hdl/scix_sqrt.sv
hdl/scix_div.sv
hdl/scix_coord.sv
hdl/segment_circle_intersection_top.sv
hdl/scix_checker.sv
tb/sv/segment_circle_intersection_top_tb.sv
